[hw/rtl/grid_point_table_nearest_macros.svh]
// ----------------------------------------------------------------------------
// Grid point table assertion macros
// Shared concurrent assertion forms, clocked on clk and masked during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_POINT_TABLE_NEAREST_MACROS_SVH
`define GRID_POINT_TABLE_NEAREST_MACROS_SVH

// Same-cycle implication.
`define GPTN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GPTN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gptn_pkg.sv]
// ----------------------------------------------------------------------------
// Grid point table package
// Sizes, command and status codes, and the structs shared by the block.
// ----------------------------------------------------------------------------
package gptn_pkg;

  localparam int ENTRIES    = 64;
  localparam int COORD_BITS = 16;
  localparam int KEY_BITS   = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_REMOVE  = 3'd1;
  localparam logic [2:0] MODE_POS     = 3'd2;
  localparam logic [2:0] MODE_CELL    = 3'd3;
  localparam logic [2:0] MODE_NEAREST = 3'd4;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_KEY_USED = 3'd1;
  localparam logic [2:0] STATUS_CELL_USED = 3'd2;
  localparam logic [2:0] STATUS_NO_KEY   = 3'd3;
  localparam logic [2:0] STATUS_NONE_DIR = 3'd4;
  localparam logic [2:0] STATUS_FULL     = 3'd5;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_EAST  = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  typedef struct packed {
    logic [2:0]                   mode;
    logic [KEY_BITS-1:0]          point_key;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic [1:0]                   direction;
  } item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]          key;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } entry_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic                         found;
    logic [KEY_BITS-1:0]          result_key;
    logic signed [COORD_BITS-1:0] result_x;
    logic signed [COORD_BITS-1:0] result_y;
  } res_t;

  // Sequencer to scan unit.
  typedef struct packed {
    logic             clr_p1;
    logic             clr_p2;
    logic             cmp;
    logic             second;
    logic [IDX_W-1:0] idx;
    logic             set_vld;
    logic             clr_vld;
    logic [IDX_W-1:0] upd_idx;
  } scan_ctl_t;

  // Scan unit to sequencer.
  typedef struct packed {
    logic                         key_hit;
    logic [IDX_W-1:0]             key_idx;
    logic signed [COORD_BITS-1:0] key_x;
    logic signed [COORD_BITS-1:0] key_y;
    logic                         cell_hit;
    logic [KEY_BITS-1:0]          cell_key;
    logic                         free_hit;
    logic [IDX_W-1:0]             free_idx;
    logic                         best_hit;
    logic [KEY_BITS-1:0]          best_key;
  } scan_sts_t;

endpackage

[hw/rtl/gptn_if.sv]
// ----------------------------------------------------------------------------
// Grid point table channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface gptn_in_if
  import gptn_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   mode;
  logic [KEY_BITS-1:0]          point_key;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic [1:0]                   direction;

  modport source (output valid, mode, point_key, x_coord, y_coord, direction,
                  input ready);
  modport sink   (input valid, mode, point_key, x_coord, y_coord, direction,
                  output ready);
endinterface

interface gptn_out_if
  import gptn_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic                         found;
  logic [KEY_BITS-1:0]          result_key;
  logic signed [COORD_BITS-1:0] result_x;
  logic signed [COORD_BITS-1:0] result_y;

  modport source (output valid, status, found, result_key, result_x, result_y,
                  input ready);
  modport sink   (input valid, status, found, result_key, result_x, result_y,
                  output ready);
endinterface

[hw/rtl/grid_point_table_nearest.sv]
// Commands: one at a time; a command word is accepted only while idle, after the
//   previous result word has moved into the output register. Nearest runs a second scan.
// Each scan reads the entry memory through its single read port, one entry per cycle.
// Reset: synchronous, active low; empties the table (all valid marks clear).
// ----------------------------------------------------------------------------
// Grid point table with nearest search
// Sequencer, entry memory and scan unit; one command word in, one result out.
// ----------------------------------------------------------------------------
`include "grid_point_table_nearest_macros.svh"

module grid_point_table_nearest
  import gptn_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  gptn_in_if.sink   in_port,
  gptn_out_if.source out_port
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN1, ST_DONE1, ST_SCAN2, ST_DONE2, ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  item_t            item_r, item_nxt;
  res_t             res_r, res_nxt;
  res_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  scan_ctl_t        ctl;
  scan_sts_t        sts;
  entry_t           rdata;
  entry_t           wdata;
  logic             mem_we;

  // Entry store: key and cell of every point.
  gptn_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (sts.free_idx),
    .wdata (wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Compare each read entry, keep matches, hold valid marks.
  gptn_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (item_r),
    .rdata (rdata),
    .sts   (sts)
  );

  assign wdata.key = item_r.point_key;
  assign wdata.x   = item_r.x_coord;
  assign wdata.y   = item_r.y_coord;

  assign in_port.ready       = (state_r == ST_IDLE);
  assign out_port.valid      = out_valid_r;
  assign out_port.status     = out_r.status;
  assign out_port.found      = out_r.found;
  assign out_port.result_key = out_r.result_key;
  assign out_port.result_x   = out_r.result_x;
  assign out_port.result_y   = out_r.result_y;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = cnt_r[IDX_W-1:0];
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_port.ready;
    mem_we        = 1'b0;
    ctl           = '0;
    ctl.cmp       = rd_vld_r;
    ctl.second    = (state_r == ST_SCAN2);
    ctl.idx       = rd_idx_r;

    case (state_r)
      ST_IDLE: begin
        // Latch the command word and start the first sweep.
        if (in_port.valid) begin
          item_nxt.mode      = in_port.mode;
          item_nxt.point_key = in_port.point_key;
          item_nxt.x_coord   = in_port.x_coord;
          item_nxt.y_coord   = in_port.y_coord;
          item_nxt.direction = in_port.direction;
          cnt_nxt            = '0;
          ctl.clr_p1         = 1'b1;
          state_nxt          = ST_SCAN1;
        end
      end
      ST_SCAN1, ST_SCAN2: begin
        // Issue one read a cycle; finish once the last read is compared.
        if (cnt_r != CNT_LAST) begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = (state_r == ST_SCAN1) ? ST_DONE1 : ST_DONE2;
        end
      end
      ST_DONE1: begin
        res_nxt   = '0;
        state_nxt = ST_OUT;
        case (item_r.mode)
          MODE_ADD: begin
            if (sts.key_hit) begin
              res_nxt.status = STATUS_KEY_USED;
            end else if (sts.cell_hit) begin
              res_nxt.status = STATUS_CELL_USED;
            end else if (!sts.free_hit) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              mem_we      = 1'b1;
              ctl.set_vld = 1'b1;
              ctl.upd_idx = sts.free_idx;
            end
          end
          MODE_REMOVE: begin
            if (!sts.key_hit) begin
              res_nxt.status = STATUS_NO_KEY;
            end else begin
              ctl.clr_vld = 1'b1;
              ctl.upd_idx = sts.key_idx;
            end
          end
          MODE_POS: begin
            if (!sts.key_hit) begin
              res_nxt.status = STATUS_NO_KEY;
            end else begin
              res_nxt.result_x = sts.key_x;
              res_nxt.result_y = sts.key_y;
            end
          end
          MODE_CELL: begin
            if (sts.cell_hit) begin
              res_nxt.found      = 1'b1;
              res_nxt.result_key = sts.cell_key;
            end
          end
          MODE_NEAREST: begin
            if (!sts.key_hit) begin
              res_nxt.status = STATUS_NO_KEY;
            end else begin
              // Origin found; sweep again for the closest point ahead.
              cnt_nxt    = '0;
              ctl.clr_p2 = 1'b1;
              state_nxt  = ST_SCAN2;
            end
          end
          default: begin
            res_nxt.status = STATUS_OK;
          end
        endcase
      end
      ST_DONE2: begin
        res_nxt = '0;
        if (sts.best_hit) begin
          res_nxt.result_key = sts.best_key;
        end else begin
          res_nxt.status = STATUS_NONE_DIR;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Advance into the output register once it is free.
        if (!out_valid_r || out_port.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  `GPTN_ASSERT_NOW(a_write_only_new, mem_we, (item_r.mode == MODE_ADD) && !sts.key_hit && !sts.cell_hit && sts.free_hit, "entry written without a clean add")
  `GPTN_ASSERT_NOW(a_read_in_sweep, rd_vld_r, (state_r == ST_SCAN1) || (state_r == ST_SCAN2), "read compare outside a sweep")
  `GPTN_ASSERT_NEXT(a_out_from_slot, !out_valid_r && (state_r != ST_OUT), !out_valid_r, "result word raised outside output step")
  `GPTN_ASSERT_NOW(a_found_ok, out_valid_r && out_r.found, out_r.status == STATUS_OK, "found flag with failing status")

endmodule

[hw/rtl/gptn_mem.sv]
// ----------------------------------------------------------------------------
// Grid point table entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gptn_mem
  import gptn_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/gptn_scan.sv]
// ----------------------------------------------------------------------------
// Grid point table scan unit
// Holds the valid marks and compares one read entry a cycle against the
// current command, keeping first key, cell and free matches and the nearest.
// ----------------------------------------------------------------------------
module gptn_scan
  import gptn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_ctl_t ctl,
  input  item_t     item,
  input  entry_t    rdata,
  output scan_sts_t sts
);

  logic [ENTRIES-1:0]           valid_r;
  logic                         key_hit_r, cell_hit_r, free_hit_r, best_hit_r;
  logic [IDX_W-1:0]             key_idx_r, free_idx_r;
  logic signed [COORD_BITS-1:0] key_x_r, key_y_r;
  logic [KEY_BITS-1:0]          cell_key_r, best_key_r;
  logic [COORD_BITS-1:0]        best_d_r;

  logic                         ent_v, key_m, cell_m, on_line, ahead, closer;
  logic signed [COORD_BITS:0]   op_a, op_b, delta;

  always_comb begin
    ent_v  = valid_r[ctl.idx];
    key_m  = ent_v && (rdata.key == item.point_key);
    cell_m = ent_v && (rdata.x == item.x_coord) && (rdata.y == item.y_coord);
    op_a   = (COORD_BITS + 1)'(rdata.y);
    op_b   = (COORD_BITS + 1)'(key_y_r);
    case (item.direction)
      DIR_NORTH: begin
        op_a = (COORD_BITS + 1)'(rdata.y);
        op_b = (COORD_BITS + 1)'(key_y_r);
      end
      DIR_SOUTH: begin
        op_a = (COORD_BITS + 1)'(key_y_r);
        op_b = (COORD_BITS + 1)'(rdata.y);
      end
      DIR_EAST: begin
        op_a = (COORD_BITS + 1)'(rdata.x);
        op_b = (COORD_BITS + 1)'(key_x_r);
      end
      default: begin
        op_a = (COORD_BITS + 1)'(key_x_r);
        op_b = (COORD_BITS + 1)'(rdata.x);
      end
    endcase
    delta   = op_a - op_b;
    on_line = (item.direction == DIR_NORTH || item.direction == DIR_SOUTH) ?
              (rdata.x == key_x_r) : (rdata.y == key_y_r);
    ahead   = !delta[COORD_BITS] && (delta != '0);
    closer  = !best_hit_r || (delta[COORD_BITS-1:0] < best_d_r);
  end

  // Valid marks: set on add, drop on remove.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.set_vld) begin
      valid_r[ctl.upd_idx] <= 1'b1;
    end else if (ctl.clr_vld) begin
      valid_r[ctl.upd_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hit_r  <= 1'b0;
      cell_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
      best_hit_r <= 1'b0;
    end else if (ctl.clr_p1) begin
      key_hit_r  <= 1'b0;
      cell_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
      best_hit_r <= 1'b0;
    end else if (ctl.clr_p2) begin
      best_hit_r <= 1'b0;
    end else if (ctl.cmp && !ctl.second) begin
      if (key_m && !key_hit_r) begin
        key_hit_r <= 1'b1;
        key_idx_r <= ctl.idx;
        key_x_r   <= rdata.x;
        key_y_r   <= rdata.y;
      end
      if (cell_m && !cell_hit_r) begin
        cell_hit_r <= 1'b1;
        cell_key_r <= rdata.key;
      end
      if (!ent_v && !free_hit_r) begin
        free_hit_r <= 1'b1;
        free_idx_r <= ctl.idx;
      end
    end else if (ctl.cmp && ctl.second) begin
      // Keep the strictly closer point so the lowest entry wins a tie.
      if (ent_v && (ctl.idx != key_idx_r) && on_line && ahead && closer) begin
        best_hit_r <= 1'b1;
        best_key_r <= rdata.key;
        best_d_r   <= delta[COORD_BITS-1:0];
      end
    end
  end

  always_comb begin
    sts.key_hit  = key_hit_r;
    sts.key_idx  = key_idx_r;
    sts.key_x    = key_x_r;
    sts.key_y    = key_y_r;
    sts.cell_hit = cell_hit_r;
    sts.cell_key = cell_key_r;
    sts.free_hit = free_hit_r;
    sts.free_idx = free_idx_r;
    sts.best_hit = best_hit_r;
    sts.best_key = best_key_r;
  end

endmodule

[tb/grid_point_table_nearest_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid point table testbench
// Sends command words to the grid point table and keeps a shadow copy of the
// table that predicts every result word. Each result word is checked field by
// field, in order, against the oldest prediction. The run covers directed
// corner cases, a full table, random traffic with idling on both channels, a
// long output hold-off, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module grid_point_table_nearest_tb
  import gptn_pkg::*;
();

  localparam int     HALF_PERIOD     = 6;
  localparam int     RESET_CYCLES    = 10;
  localparam int     KEY_POOL        = 40;
  localparam int     RANDOM_ROUNDS   = 4;
  localparam int     ROUND_WORDS     = 300;
  localparam int     STEADY_WORDS    = 150;
  localparam int     HOLD_OFF_WORDS  = 6;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     DRAIN_CYCLES    = 2 * ENTRIES + 16;
  localparam int     PRINT_LIMIT     = 100;
  localparam longint CYCLE_LIMIT     = 1_200_000;

  // Modes above nearest are unused by the block.
  localparam logic [2:0] MODE_SPARE_LO = MODE_NEAREST + 3'd1;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [KEY_BITS-1:0]          KEY_MAX   = '1;

  logic clk = 1'b0;
  logic rst_n;

  gptn_in_if  in_if ();
  gptn_out_if out_if ();

  grid_point_table_nearest i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if.sink),
    .out_port (out_if.source)
  );

  // Shadow table: what the block should hold after every accepted word.
  logic                         tbl_valid [ENTRIES];
  logic [KEY_BITS-1:0]          tbl_key   [ENTRIES];
  logic signed [COORD_BITS-1:0] tbl_x     [ENTRIES];
  logic signed [COORD_BITS-1:0] tbl_y     [ENTRIES];

  // Result words predicted but not yet seen, oldest first.
  res_t replies_due [$];

  logic [KEY_BITS-1:0] key_pool [KEY_POOL];

  int     mismatch_cnt  = 0;
  longint cycle_cnt     = 0;
  bit     gaps_on       = 1'b1;
  bit     stalls_on     = 1'b1;
  int     hold_off_reqs = 0;

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + longint'(1);
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int find_key_entry(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_cell_entry(logic signed [COORD_BITS-1:0] cx,
                                         logic signed [COORD_BITS-1:0] cy);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_x[i] == cx && tbl_y[i] == cy) return i;
    return -1;
  endfunction

  // Apply one command word to the shadow table and return its result word.
  function automatic res_t apply_table_cmd(item_t cmd);
    res_t   r;
    int     idx;
    int     best;
    logic   on_line;
    longint ox, oy, delta, best_dist;
    r = '0;
    case (cmd.mode)
      MODE_ADD: begin
        // Duplicate key wins over occupied cell, which wins over a full table.
        if (find_key_entry(cmd.point_key) >= 0) begin
          r.status = STATUS_KEY_USED;
        end else if (find_cell_entry(cmd.x_coord, cmd.y_coord) >= 0) begin
          r.status = STATUS_CELL_USED;
        end else begin
          idx = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!tbl_valid[i]) idx = i;
          if (idx < 0) begin
            r.status = STATUS_FULL;
          end else begin
            tbl_valid[idx] = 1'b1;
            tbl_key[idx]   = cmd.point_key;
            tbl_x[idx]     = cmd.x_coord;
            tbl_y[idx]     = cmd.y_coord;
          end
        end
      end
      MODE_REMOVE: begin
        idx = find_key_entry(cmd.point_key);
        if (idx < 0) r.status = STATUS_NO_KEY;
        else tbl_valid[idx] = 1'b0;
      end
      MODE_POS: begin
        idx = find_key_entry(cmd.point_key);
        if (idx < 0) begin
          r.status = STATUS_NO_KEY;
        end else begin
          r.result_x = tbl_x[idx];
          r.result_y = tbl_y[idx];
        end
      end
      MODE_CELL: begin
        idx = find_cell_entry(cmd.x_coord, cmd.y_coord);
        if (idx >= 0) begin
          r.found      = 1'b1;
          r.result_key = tbl_key[idx];
        end
      end
      MODE_NEAREST: begin
        idx = find_key_entry(cmd.point_key);
        if (idx < 0) begin
          r.status = STATUS_NO_KEY;
        end else begin
          // Distances are taken wide so that the grid extremes cannot wrap.
          ox        = longint'(tbl_x[idx]);
          oy        = longint'(tbl_y[idx]);
          best      = -1;
          best_dist = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            case (cmd.direction)
              DIR_NORTH: begin
                on_line = (tbl_x[i] == tbl_x[idx]);
                delta   = longint'(tbl_y[i]) - oy;
              end
              DIR_SOUTH: begin
                on_line = (tbl_x[i] == tbl_x[idx]);
                delta   = oy - longint'(tbl_y[i]);
              end
              DIR_EAST: begin
                on_line = (tbl_y[i] == tbl_y[idx]);
                delta   = longint'(tbl_x[i]) - ox;
              end
              default: begin
                // west
                on_line = (tbl_y[i] == tbl_y[idx]);
                delta   = ox - longint'(tbl_x[i]);
              end
            endcase
            if (tbl_valid[i] && i != idx && on_line && delta > 0 &&
                (best < 0 || delta < best_dist)) begin
              best      = i;
              best_dist = delta;
            end
          end
          if (best < 0) r.status = STATUS_NONE_DIR;
          else r.result_key = tbl_key[best];
        end
      end
      default: begin
        // Unused modes leave the table alone and return an all-zero word.
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic item_t make_cmd(logic [2:0] mode, logic [KEY_BITS-1:0] k,
                                     logic signed [COORD_BITS-1:0] cx,
                                     logic signed [COORD_BITS-1:0] cy,
                                     logic [1:0] dir);
    item_t c;
    c.mode      = mode;
    c.point_key = k;
    c.x_coord   = cx;
    c.y_coord   = cy;
    c.direction = dir;
    return c;
  endfunction

  // Offer one command word and hold it until the block takes it. Valid stays
  // high on return so that a following word goes out back to back.
  task automatic send_cmd(input item_t cmd);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= cmd.mode;
    in_if.point_key <= cmd.point_key;
    in_if.x_coord   <= cmd.x_coord;
    in_if.y_coord   <= cmd.y_coord;
    in_if.direction <= cmd.direction;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    replies_due.push_back(apply_table_cmd(cmd));
  endtask

  // Mostly keys from a small pool so that keys collide and get removed.
  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 19) == 0) return KEY_BITS'($urandom);
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  // Mostly a small window around the origin, so cells clash and rows and
  // columns share points; now and then anywhere on the grid.
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    int v;
    if ($urandom_range(0, 6) == 0) return COORD_BITS'($urandom);
    v = $urandom_range(0, 8);
    return COORD_BITS'(v - 4);
  endfunction

  task automatic send_random_cmds(input int n);
    int         pick;
    logic [2:0] mode;
    for (int w = 0; w < n; w++) begin
      pick = $urandom_range(0, 99);
      if (pick < 34)      mode = MODE_ADD;
      else if (pick < 50) mode = MODE_REMOVE;
      else if (pick < 63) mode = MODE_POS;
      else if (pick < 77) mode = MODE_CELL;
      else if (pick < 97) mode = MODE_NEAREST;
      else                mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      send_cmd(make_cmd(mode, pick_key(), pick_coord(), pick_coord(),
                        2'($urandom_range(DIR_NORTH, DIR_WEST))));
    end
  endtask

  // Remove every point the shadow table holds.
  task automatic clear_table();
    logic [KEY_BITS-1:0] doomed [$];
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i]) doomed.push_back(tbl_key[i]);
    foreach (doomed[i])
      send_cmd(make_cmd(MODE_REMOVE, doomed[i], '0, '0, DIR_NORTH));
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern and result check
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint want,
                                 input longint got);
    if (mismatch_cnt < PRINT_LIMIT)
      $display("ERROR at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  initial begin : drive_ready
    int hold_offs_done;
    hold_offs_done = 0;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_offs_done != hold_off_reqs) begin
        // Long hold-off: the block fills up and must stall its input.
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result word with nothing pending, status", '0,
                        longint'(out_if.status));
      end else begin
        want = replies_due.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", longint'(want.status), longint'(out_if.status));
        if (out_if.found !== want.found)
          report_mismatch("found", longint'(want.found), longint'(out_if.found));
        if (out_if.result_key !== want.result_key)
          report_mismatch("result_key", longint'(want.result_key),
                          longint'(out_if.result_key));
        if (out_if.result_x !== want.result_x)
          report_mismatch("result_x", longint'(want.result_x),
                          longint'(out_if.result_x));
        if (out_if.result_y !== want.result_y)
          report_mismatch("result_y", longint'(want.result_y),
                          longint'(out_if.result_y));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // Empty table: every key lookup misses, cell lookup finds nothing.
    send_cmd(make_cmd(MODE_POS,     '0,      '0,        '0,        DIR_NORTH));
    send_cmd(make_cmd(MODE_REMOVE,  KEY_MAX, COORD_MAX, COORD_MIN, DIR_WEST));
    send_cmd(make_cmd(MODE_NEAREST, 16'h1234, '0,       '0,        DIR_EAST));
    send_cmd(make_cmd(MODE_CELL,    '0,      COORD_MIN, COORD_MAX, DIR_SOUTH));
    // Corners of the grid, then a duplicate key and a clashing cell.
    send_cmd(make_cmd(MODE_ADD, '0,      COORD_MIN, COORD_MIN, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, KEY_MAX, COORD_MAX, COORD_MAX, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, '0,      16'sd5,    16'sd5,    DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, 16'h0001, COORD_MAX, COORD_MAX, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, 16'h8000, COORD_MIN, COORD_MAX, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, 16'h7FFF, COORD_MIN, '0,        DIR_NORTH));
    // Nearest across the full span; the closer of two must win.
    send_cmd(make_cmd(MODE_NEAREST, '0,       '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_NEAREST, 16'h8000, '0, '0, DIR_SOUTH));
    send_cmd(make_cmd(MODE_NEAREST, '0,       '0, '0, DIR_SOUTH));
    send_cmd(make_cmd(MODE_NEAREST, 16'h8000, '0, '0, DIR_EAST));
    send_cmd(make_cmd(MODE_NEAREST, KEY_MAX,  '0, '0, DIR_WEST));
    send_cmd(make_cmd(MODE_NEAREST, KEY_MAX,  '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_POS,  KEY_MAX, '0,        '0,     DIR_NORTH));
    send_cmd(make_cmd(MODE_CELL, '0,      COORD_MIN, '0,     DIR_NORTH));
    send_cmd(make_cmd(MODE_CELL, KEY_MAX, 16'sd1,    16'sd1, DIR_NORTH));
    // Unused modes with every other field at all ones.
    send_cmd(make_cmd(MODE_SPARE_LO,         KEY_MAX, '1, '1, DIR_WEST));
    send_cmd(make_cmd(MODE_SPARE_LO + 3'd1,  KEY_MAX, '1, '1, DIR_WEST));
    send_cmd(make_cmd(MODE_SPARE_HI,         KEY_MAX, '1, '1, DIR_WEST));
    // Remove, then every key command on the removed key misses.
    send_cmd(make_cmd(MODE_REMOVE, '0, '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_REMOVE, '0, '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_POS,    '0, '0, '0, DIR_NORTH));
  endtask

  task automatic test_full_table();
    logic [KEY_BITS-1:0]          base;
    logic signed [COORD_BITS-1:0] cx, cy;
    base = 16'hA000;
    clear_table();
    // Fill every entry on an 8-wide patch so rows and columns are crowded.
    for (int i = 0; i < ENTRIES; i++) begin
      cx = COORD_BITS'(-20 + i % 8);
      cy = COORD_BITS'(30 - i / 8);
      send_cmd(make_cmd(MODE_ADD, base + KEY_BITS'(i), cx, cy, DIR_NORTH));
    end
    send_cmd(make_cmd(MODE_ADD, base + KEY_BITS'(ENTRIES), 16'sd100, 16'sd100, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, base, 16'sd100, 16'sd100, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, 16'hBEEF, -16'sd20, 16'sd30, DIR_NORTH));
    for (int d = DIR_NORTH; d <= DIR_WEST; d++)
      send_cmd(make_cmd(MODE_NEAREST, base + 16'd9, '0, '0, d[1:0]));
    send_cmd(make_cmd(MODE_NEAREST, base, '0, '0, DIR_WEST));
    send_cmd(make_cmd(MODE_CELL, '0, -16'sd16, 16'sd28, DIR_NORTH));
    // Free two entries; the next adds reuse them, then the table is full again.
    send_cmd(make_cmd(MODE_REMOVE, base + 16'd5,  '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_REMOVE, base + 16'd40, '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, base + KEY_BITS'(ENTRIES), 16'sd100, 16'sd100, DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, base + KEY_BITS'(ENTRIES + 1), -16'sd15, 16'sd30,
                      DIR_NORTH));
    send_cmd(make_cmd(MODE_ADD, base + KEY_BITS'(ENTRIES + 2), 16'sd101, 16'sd100,
                      DIR_NORTH));
    send_cmd(make_cmd(MODE_POS, base + KEY_BITS'(ENTRIES), '0, '0, DIR_NORTH));
    send_cmd(make_cmd(MODE_NEAREST, base + KEY_BITS'(ENTRIES + 1), '0, '0, DIR_WEST));
    clear_table();
  endtask

  task automatic test_random();
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      send_random_cmds(ROUND_WORDS);
      // Start each round from an empty table so adds do not pile up.
      clear_table();
    end
  endtask

  task automatic test_hold_off();
    // Hold the result channel and keep offering words into the stall.
    hold_off_reqs++;
    send_random_cmds(HOLD_OFF_WORDS);
  endtask

  task automatic test_steady();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_random_cmds(STEADY_WORDS);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_BITS'($urandom);

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_ADD;
    in_if.point_key <= '0;
    in_if.x_coord   <= '0;
    in_if.y_coord   <= '0;
    in_if.direction <= DIR_NORTH;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_random();
    test_hold_off();
    test_steady();

    // Drop valid, drain the pending words, then allow a nearest's latency.
    in_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
